// ----- design/ring_buffer_packetizer_with_timeout_core_defines.svh -----
// Assertion macros for the ring buffer packetizer.
// Included by the top level; no other dependencies.
`ifndef RING_BUFFER_PACKETIZER_WITH_TIMEOUT_CORE_DEFINES_SVH
`define RING_BUFFER_PACKETIZER_WITH_TIMEOUT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define RBPKT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low
`define RBPKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBPKT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RBPKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/rbpkt_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the packetizer.
// No dependencies.
package rbpkt_pkg;

    localparam int DEF_RING_DEPTH     = 256;
    localparam int DEF_PACKET_PAYLOAD = 63;
    localparam int BYTE_W             = 8;

    localparam logic [BYTE_W-1:0] FLUSH_TIMEOUT_RESET = 8'd5;

    // Input item kinds carried on tuser
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic append;       // write data byte, advance write pointer
        logic wait_inc;     // waiting tick: bump wait counter
        logic start_full;   // begin a full packet
        logic start_short;  // begin a short flush packet
        logic issue;        // push one packet slot into the output pipe
        logic issue_len;    // slot is the length byte
        logic issue_last;   // slot is the final byte
    } rbpkt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic held_zero;    // ring empty
        logic held_full;    // at least one payload held
        logic wait_hit;     // next wait count equals the timeout
        logic issue_ok;     // output pipe can take a slot
    } rbpkt_stat_t;

endpackage

// ----- design/rbpkt_ctrl.sv -----
`timescale 1ns / 1ps
// Packetizer controller: accepts input transactions and sequences packet slots.
// Depends on rbpkt_pkg.
module rbpkt_ctrl #(
    parameter int PACKET_PAYLOAD = rbpkt_pkg::DEF_PACKET_PAYLOAD
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_tuser,
    input  rbpkt_pkg::rbpkt_stat_t  stat,
    output rbpkt_pkg::rbpkt_cmd_t   cmd
);
    import rbpkt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam logic [BYTE_W-1:0] LAST_SLOT = BYTE_W'(PACKET_PAYLOAD);

    logic              state_reg, state_next;
    logic [BYTE_W-1:0] slot_reg, slot_next;

    // Decide commands and next state
    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == KIND_APPEND) begin
                        cmd.append = 1'b1;
                    end else if (!stat.held_zero) begin
                        if (stat.held_full) begin
                            cmd.start_full = 1'b1;
                            state_next     = ST_EMIT;
                            slot_next      = '0;
                        end else if (stat.wait_hit) begin
                            cmd.start_short = 1'b1;
                            state_next      = ST_EMIT;
                            slot_next       = '0;
                        end else begin
                            cmd.wait_inc = 1'b1;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (stat.issue_ok) begin
                    cmd.issue      = 1'b1;
                    cmd.issue_len  = (slot_reg == '0);
                    cmd.issue_last = (slot_reg == LAST_SLOT);
                    if (slot_reg == LAST_SLOT) begin
                        state_next = ST_IDLE;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and slot count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

// ----- design/rbpkt_datapath.sv -----
`timescale 1ns / 1ps
// Packetizer datapath: ring memory, pointers, wait counter, timeout register
// and the two-stage output pipe. Depends on rbpkt_pkg.
module rbpkt_datapath #(
    parameter int RING_DEPTH     = rbpkt_pkg::DEF_RING_DEPTH,
    parameter int PACKET_PAYLOAD = rbpkt_pkg::DEF_PACKET_PAYLOAD
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [rbpkt_pkg::BYTE_W-1:0] s_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rbpkt_pkg::BYTE_W-1:0] cfg_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rbpkt_pkg::BYTE_W-1:0] m_tdata,
    output logic                         m_tlast,
    input  rbpkt_pkg::rbpkt_cmd_t        cmd,
    output rbpkt_pkg::rbpkt_stat_t       stat
);
    import rbpkt_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = (PTR_W + 1 > BYTE_W) ? PTR_W + 1 : BYTE_W;
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0]  PAYLOAD_C = CNT_W'(PACKET_PAYLOAD);
    localparam logic [BYTE_W-1:0] PAYLOAD_B = BYTE_W'(PACKET_PAYLOAD);

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];

    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [BYTE_W-1:0] wait_reg, wait_next;
    logic [BYTE_W-1:0] timeout_reg;
    logic [BYTE_W-1:0] len_reg;
    logic [BYTE_W-1:0] rem_reg;

    logic [CNT_W-1:0]  rd_ext, wr_ext, held;
    logic [BYTE_W-1:0] wait_inc;
    logic              out_adv, rd_en;

    // Output pipe: read stage then output register
    logic              s1_valid_reg;
    logic              s1_use_ram_reg;
    logic              s1_last_reg;
    logic [BYTE_W-1:0] s1_const_reg;
    logic [BYTE_W-1:0] ram_q_reg;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;
    logic              m_last_reg;

    // Held count is the pointer distance around the ring
    assign rd_ext = CNT_W'(rd_ptr_reg);
    assign wr_ext = CNT_W'(wr_ptr_reg);
    assign held   = (wr_ext >= rd_ext) ? (wr_ext - rd_ext) : (DEPTH_C - rd_ext + wr_ext);

    assign wait_inc = wait_reg + 1'b1;
    assign out_adv  = !m_valid_reg || m_tready;
    assign rd_en    = cmd.issue && !cmd.issue_len && (rem_reg != '0);

    assign stat.held_zero = (held == '0);
    assign stat.held_full = (held >= PAYLOAD_C);
    assign stat.wait_hit  = (wait_inc == timeout_reg);
    assign stat.issue_ok  = !s1_valid_reg || out_adv;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

    // Advance pointers and wait counter
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        wait_next   = wait_reg;
        if (cmd.append) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (cmd.start_full || cmd.start_short) begin
            wait_next = '0;
        end else if (cmd.wait_inc) begin
            wait_next = wait_inc;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            wait_reg     <= '0;
            timeout_reg  <= FLUSH_TIMEOUT_RESET;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            wait_reg   <= wait_next;
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
            if (cmd.issue) begin
                s1_valid_reg <= 1'b1;
            end else if (out_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Latch packet length and remaining payload at packet start; count the remainder down on each read
    always_ff @(posedge aclk) begin
        if (cmd.start_full) begin
            len_reg <= PAYLOAD_B;
            rem_reg <= PAYLOAD_B;
        end else if (cmd.start_short) begin
            len_reg <= held[BYTE_W-1:0];
            rem_reg <= held[BYTE_W-1:0];
        end else if (rd_en) begin
            rem_reg <= rem_reg - 1'b1;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            ring_mem[wr_ptr_reg] <= s_tdata;
        end
        if (rd_en) begin
            ram_q_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // Payload of the output pipe
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            s1_use_ram_reg <= rd_en;
            s1_const_reg   <= cmd.issue_len ? len_reg : '0;
            s1_last_reg    <= cmd.issue_last;
        end
        if (out_adv) begin
            m_data_reg <= s1_use_ram_reg ? ram_q_reg : s1_const_reg;
            m_last_reg <= s1_last_reg;
        end
    end

endmodule

// ----- design/ring_buffer_packetizer_with_timeout_core.sv -----
`timescale 1ns / 1ps
`include "ring_buffer_packetizer_with_timeout_core_defines.svh"
// Top level of the byte ring buffer packetizer with flush timeout.
// Depends on rbpkt_pkg, rbpkt_ctrl, rbpkt_datapath and the defines header.
//
//  Channel   Direction  Handshake           Contents
//  s_        in         s_tvalid/s_tready   byte to append or tick
//  m_        out        m_tvalid/m_tready   packet bytes, tlast on the final byte
//  cfg_      in         cfg_valid/cfg_ready flush timeout register
//
// An append or a tick that sends nothing leaves s_tready high.
// A tick that sends a packet holds s_tready low while its PACKET_PAYLOAD + 1
// bytes go into the output pipe, one per cycle while the pipe can take a slot,
// paced by the single read port of the ring memory.
// m_tready low stalls the pipe and with it the packet sequencing.
// Reset is synchronous; the ring memory is not cleared and needs no sweep.
module ring_buffer_packetizer_with_timeout_core #(
    parameter int RING_DEPTH     = rbpkt_pkg::DEF_RING_DEPTH,
    parameter int PACKET_PAYLOAD = rbpkt_pkg::DEF_PACKET_PAYLOAD
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rbpkt_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                         s_tuser,   // [0] kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rbpkt_pkg::BYTE_W-1:0] m_tdata,   // [7:0] packet_byte
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rbpkt_pkg::BYTE_W-1:0] cfg_data   // [7:0] flush_timeout
);
    import rbpkt_pkg::*;

    rbpkt_cmd_t  cmd;
    rbpkt_stat_t stat;

    rbpkt_ctrl #(
        .PACKET_PAYLOAD (PACKET_PAYLOAD)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbpkt_datapath #(
        .RING_DEPTH     (RING_DEPTH),
        .PACKET_PAYLOAD (PACKET_PAYLOAD)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Packets start only on an accepted tick transaction
    `RBPKT_ASSERT_SAME(a_start_on_tick, aclk, aresetn, cmd.start_full || cmd.start_short, s_tvalid && s_tready && s_tuser == KIND_TICK, "packet start without tick")
    // A full packet needs at least one payload held
    `RBPKT_ASSERT_SAME(a_full_needs_data, aclk, aresetn, cmd.start_full, !stat.held_zero && stat.held_full, "full packet with too few bytes")
    // Never push a slot into a blocked output pipe
    `RBPKT_ASSERT_SAME(a_issue_ok, aclk, aresetn, cmd.issue, stat.issue_ok, "slot issued into full pipe")
    // After the final slot the input side opens again
    `RBPKT_ASSERT_NEXT(a_last_reopens, aclk, aresetn, cmd.issue && cmd.issue_last, s_tready, "input not reopened after packet")

endmodule
